// File: sv/lnp_euler_pkg.sv
// Shared constants, codes and phase table for the LNP/mRNA/epitope Euler step.
`default_nettype none
package lnp_euler_pkg;

  // Default widths
  localparam int AMOUNT_BITS_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Integer bits carried by every fraction register (Q4.F)
  localparam int FRAC_INT_BITS = 4;

  // Configuration register file
  localparam int NUM_CFG        = 6;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ESCAPE        = 3'd0,
    CFG_UNCOAT        = 3'd1,
    CFG_RELEASE       = 3'd2,
    CFG_MRNA_DECAY    = 3'd3,
    CFG_TRANSLATION   = 3'd4,
    CFG_EPITOPE_DECAY = 3'd5
  } cfg_index_t;

  // Pools carried down the pipe
  localparam int NUM_POOLS = 5;
  localparam int P_ENDO    = 0;
  localparam int P_FREE    = 1;
  localparam int P_UNC     = 2;
  localparam int P_MRNA    = 3;
  localparam int P_EPI     = 4;

  // One phase = one multiply stage + one apply stage
  localparam int NUM_PHASES = 6;
  localparam int PIPE_DEPTH = 2 * NUM_PHASES;

  typedef enum logic [1:0] {
    KIND_TRANSFER = 2'd0,  // move min(f*src, src) from src to dst
    KIND_ADD      = 2'd1,  // dst += f*src, src unchanged
    KIND_DECAY    = 2'd2   // src -= f*src, or zero when f >= 1
  } phase_kind_t;

  function automatic int phase_src(input int ph);
    int r;
    case (ph)
      0:       r = P_ENDO;
      1:       r = P_FREE;
      2:       r = P_UNC;
      3:       r = P_MRNA;
      4:       r = P_MRNA;
      default: r = P_EPI;
    endcase
    return r;
  endfunction

  function automatic int phase_dst(input int ph);
    int r;
    case (ph)
      0:       r = P_FREE;
      1:       r = P_UNC;
      2:       r = P_MRNA;
      3:       r = P_MRNA;
      default: r = P_EPI;
    endcase
    return r;
  endfunction

  function automatic phase_kind_t phase_kind(input int ph);
    phase_kind_t r;
    case (ph)
      0, 1, 2: r = KIND_TRANSFER;
      4:       r = KIND_ADD;
      default: r = KIND_DECAY;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/lnp_mrna_epitope_euler_step.sv
// Top level: streaming forward-Euler update of one cell's nanoparticle/mRNA/epitope pools.
`default_nettype none
// One beat in = one cell's five Q16.16 amounts; one beat out = the same five amounts
// after one Euler step (escape, uncoating, release, mRNA decay, translation, epitope
// decay, in that order). The block is a 12-stage pipeline: each of the six steps takes
// one stage for its fraction-times-amount multiply and one stage to clamp, subtract and
// saturate-add. A beat is accepted every cycle while the output side keeps up. Each stage
// has its own valid bit and an empty stage still accepts when the stage after it is full,
// so bubbles squeeze out under back-pressure. The six fraction registers (Q4.F, dt times
// rate) are written through the cfg_ port and must only change while the pipe is empty;
// writes to an index past the last register are dropped.
module lnp_mrna_epitope_euler_step #(
  parameter int AMOUNT_BITS   = lnp_euler_pkg::AMOUNT_BITS_DEF,
  parameter int FRACTION_BITS = lnp_euler_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // configuration
  input  wire logic                                      cfg_we,
  input  wire logic [lnp_euler_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [FRACTION_BITS+lnp_euler_pkg::FRAC_INT_BITS-1:0] cfg_wdata,
  // input beat
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [AMOUNT_BITS-1:0]                    in_endosome_amount,
  input  wire logic [AMOUNT_BITS-1:0]                    in_free_amount,
  input  wire logic [AMOUNT_BITS-1:0]                    in_uncoated_amount,
  input  wire logic [AMOUNT_BITS-1:0]                    in_mrna_amount,
  input  wire logic [AMOUNT_BITS-1:0]                    in_epitope_amount,
  // result beat
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [AMOUNT_BITS-1:0]                         out_new_endosome,
  output logic [AMOUNT_BITS-1:0]                         out_new_free,
  output logic [AMOUNT_BITS-1:0]                         out_new_uncoated,
  output logic [AMOUNT_BITS-1:0]                         out_new_mrna,
  output logic [AMOUNT_BITS-1:0]                         out_new_epitope
);

  localparam int AW  = AMOUNT_BITS;
  localparam int CW  = FRACTION_BITS + lnp_euler_pkg::FRAC_INT_BITS; // fraction width
  localparam int PW  = AW + CW;                                      // full product
  localparam int QW  = PW - FRACTION_BITS;                           // product >> F
  localparam int NPH = lnp_euler_pkg::NUM_PHASES;
  localparam int NP  = lnp_euler_pkg::NUM_POOLS;

  // ---------------------------------------------------------------------------
  // Fraction registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] frac_r [NPH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPH; i++) frac_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lnp_euler_pkg::CFG_ESCAPE:        frac_r[0] <= cfg_wdata;
        lnp_euler_pkg::CFG_UNCOAT:        frac_r[1] <= cfg_wdata;
        lnp_euler_pkg::CFG_RELEASE:       frac_r[2] <= cfg_wdata;
        lnp_euler_pkg::CFG_MRNA_DECAY:    frac_r[3] <= cfg_wdata;
        lnp_euler_pkg::CFG_TRANSLATION:   frac_r[4] <= cfg_wdata;
        lnp_euler_pkg::CFG_EPITOPE_DECAY: frac_r[5] <= cfg_wdata;
        default: ;  // index past the register file: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline storage. Phase j: multiply stage (m) then apply stage (a).
  // ---------------------------------------------------------------------------
  logic [AW-1:0] amt_m_r [NPH][NP];   // pools riding beside the product
  logic [QW-1:0] prod_r  [NPH];       // floor(src * frac / 2^F), unsaturated
  logic          vm_r    [NPH];
  logic [AW-1:0] amt_a_r [NPH][NP];   // pools after the phase is applied
  logic          va_r    [NPH];

  logic          rdy_m   [NPH];
  logic          rdy_a   [NPH];

  logic [AW-1:0] in_amt  [NP];

  assign in_amt[lnp_euler_pkg::P_ENDO] = in_endosome_amount;
  assign in_amt[lnp_euler_pkg::P_FREE] = in_free_amount;
  assign in_amt[lnp_euler_pkg::P_UNC]  = in_uncoated_amount;
  assign in_amt[lnp_euler_pkg::P_MRNA] = in_mrna_amount;
  assign in_amt[lnp_euler_pkg::P_EPI]  = in_epitope_amount;

  assign in_ready = rdy_m[0];

  for (genvar j = 0; j < NPH; j++) begin : g_phase
    localparam int SRC = lnp_euler_pkg::phase_src(j);
    localparam int DST = lnp_euler_pkg::phase_dst(j);
    localparam lnp_euler_pkg::phase_kind_t KIND = lnp_euler_pkg::phase_kind(j);

    logic          vin;
    logic [AW-1:0] amt_in  [NP];
    logic [PW-1:0] prod_full;
    logic [QW-1:0] prod_nxt;
    logic [AW-1:0] sat;
    logic [AW-1:0] amt_nxt [NP];
    logic          down_rdy;

    // ----- stage hookup -----
    if (j == 0) begin : g_first
      assign vin = in_valid;
      for (genvar p = 0; p < NP; p++) begin : g_p
        assign amt_in[p] = in_amt[p];
      end
    end else begin : g_next
      assign vin = va_r[j-1];
      for (genvar p = 0; p < NP; p++) begin : g_p
        assign amt_in[p] = amt_a_r[j-1][p];
      end
    end

    if (j == NPH - 1) begin : g_last
      assign down_rdy = out_ready;
    end else begin : g_mid
      assign down_rdy = rdy_m[j+1];
    end

    // a stage takes a new beat when empty or when its beat moves on
    assign rdy_a[j] = !va_r[j] || down_rdy;
    assign rdy_m[j] = !vm_r[j] || rdy_a[j];

    // ----- multiply stage -----
    assign prod_full = PW'(amt_in[SRC]) * PW'(frac_r[j]);
    assign prod_nxt  = prod_full[PW-1:FRACTION_BITS];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vm_r[j] <= 1'b0;
      end else if (rdy_m[j]) begin
        vm_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_m[j] && vin) begin
        prod_r[j] <= prod_nxt;
        for (int p = 0; p < NP; p++) amt_m_r[j][p] <= amt_in[p];
      end
    end

    // ----- apply stage -----
    // product saturates at the amount maximum
    assign sat = (|prod_r[j][QW-1:AW]) ? {AW{1'b1}} : prod_r[j][AW-1:0];

    always_comb begin
      logic [AW-1:0] mv;
      logic [AW:0]   sum;
      for (int p = 0; p < NP; p++) amt_nxt[p] = amt_m_r[j][p];
      mv  = '0;
      sum = '0;
      case (KIND)
        lnp_euler_pkg::KIND_TRANSFER: begin
          mv           = (sat > amt_m_r[j][SRC]) ? amt_m_r[j][SRC] : sat;
          amt_nxt[SRC] = amt_m_r[j][SRC] - mv;
          sum          = {1'b0, amt_m_r[j][DST]} + {1'b0, mv};
          amt_nxt[DST] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
        end
        lnp_euler_pkg::KIND_ADD: begin
          sum          = {1'b0, amt_m_r[j][DST]} + {1'b0, sat};
          amt_nxt[DST] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
        end
        default: begin
          // decay factor at or below zero when fraction >= 1
          if (|frac_r[j][CW-1:FRACTION_BITS]) begin
            amt_nxt[SRC] = '0;
          end else begin
            amt_nxt[SRC] = amt_m_r[j][SRC] - sat;
          end
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
      end else if (rdy_a[j]) begin
        va_r[j] <= vm_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_a[j] && vm_r[j]) begin
        for (int p = 0; p < NP; p++) amt_a_r[j][p] <= amt_nxt[p];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat straight from the last apply stage
  // ---------------------------------------------------------------------------
  assign out_valid        = va_r[NPH-1];
  assign out_new_endosome = amt_a_r[NPH-1][lnp_euler_pkg::P_ENDO];
  assign out_new_free     = amt_a_r[NPH-1][lnp_euler_pkg::P_FREE];
  assign out_new_uncoated = amt_a_r[NPH-1][lnp_euler_pkg::P_UNC];
  assign out_new_mrna     = amt_a_r[NPH-1][lnp_euler_pkg::P_MRNA];
  assign out_new_epitope  = amt_a_r[NPH-1][lnp_euler_pkg::P_EPI];

endmodule
`default_nettype wire

// File: sv/lnp_euler_chk.sv
// Port-level checker for the Euler step pipeline, bound to the top level.
`default_nettype none
module lnp_euler_chk #(
  parameter int AMOUNT_BITS = lnp_euler_pkg::AMOUNT_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [AMOUNT_BITS-1:0] out_new_endosome,
  input wire logic [AMOUNT_BITS-1:0] out_new_epitope
);

  localparam int DEPTH = lnp_euler_pkg::PIPE_DEPTH;
  localparam int CNT_BITS = $clog2(DEPTH + 2);

  logic                in_beat;
  logic                out_beat;
  logic [CNT_BITS-1:0] inflight_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // no result beat without an outstanding input beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result beat with nothing in flight");

  // never more beats held than stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_BITS'(DEPTH))
    else $error("more beats in flight than pipeline stages");

  // an empty pipe always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == '0 |-> in_ready)
    else $error("in_ready low with empty pipe");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_endosome)
      && $stable(out_new_epitope))
    else $error("stalled result beat changed");

endmodule

bind lnp_mrna_epitope_euler_step lnp_euler_chk #(
  .AMOUNT_BITS(AMOUNT_BITS)
) u_lnp_euler_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_new_endosome (out_new_endosome),
  .out_new_epitope  (out_new_epitope)
);
`default_nettype wire
